// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared sizes, command and status codes, and the cell interface types.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH     = 16;
  localparam int TAG_BITS  = 8;
  localparam int PRIO_BITS = 8;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  localparam int IN_BITS  = 2 + TAG_BITS + PRIO_BITS;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 2 + TAG_BITS + PRIO_BITS + 1 + TAG_BITS + PRIO_BITS + CNT_BITS;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic                 valid;
    logic [TAG_BITS-1:0]  tag;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic                 en;
    logic [1:0]           cmd;
    logic [TAG_BITS-1:0]  tag;
    logic [PRIO_BITS-1:0] prio;
  } op_t;

  typedef struct packed {
    logic                 take;
    logic                 hit;
    logic [TAG_BITS-1:0]  tag;
    logic [PRIO_BITS-1:0] prio;
  } link_t;

endpackage

// ===== design/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one slot; shifts toward the tail on insert and toward the head on
// pop or remove, and passes the insert and tag-match chain to the next cell.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  spq_pkg::op_t   op,
  input  spq_pkg::entry_t prev_ent,
  input  spq_pkg::entry_t next_ent,
  input  spq_pkg::link_t chain_in,
  output spq_pkg::link_t chain_out,
  output spq_pkg::entry_t ent
);

  spq_pkg::entry_t ent_r;
  spq_pkg::entry_t ent_nxt;
  logic            take;
  logic            match;

  assign take  = !ent_r.valid || (ent_r.prio < op.prio);
  assign match = ent_r.valid && (ent_r.tag == op.tag);

  always_comb begin
    chain_out.take = take;
    chain_out.hit  = chain_in.hit || match;
    if (match && !chain_in.hit) begin
      chain_out.tag  = ent_r.tag;
      chain_out.prio = ent_r.prio;
    end else begin
      chain_out.tag  = chain_in.tag;
      chain_out.prio = chain_in.prio;
    end
  end

  always_comb begin
    ent_nxt = ent_r;
    if (op.en) begin
      case (op.cmd)
        spq_pkg::CMD_PUSH: begin
          if (take && chain_in.take) begin
            ent_nxt = prev_ent;
          end else if (take) begin
            ent_nxt.valid = 1'b1;
            ent_nxt.tag   = op.tag;
            ent_nxt.prio  = op.prio;
          end
        end
        spq_pkg::CMD_POP: begin
          ent_nxt = next_ent;
        end
        spq_pkg::CMD_REMOVE: begin
          if (chain_out.hit) begin
            ent_nxt = next_ent;
          end
        end
        default: begin
          ent_nxt = ent_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ent_r.tag  <= ent_nxt.tag;
    ent_r.prio <= ent_nxt.prio;
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
  end

  assign ent = ent_r;

endmodule

// ===== design/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue
// Keeps up to DEPTH tagged entries in descending priority order, equal
// priorities first in, first out, in a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream carries one command per transfer: push, pop head, or remove
//   the entry nearest the head whose tag matches. Every command gives one
//   result transfer on the output stream with the status, the popped or
//   removed entry, the head entry and entry count after the command.
//   All cells update at the input transfer; a pending result register then
//   feeds the output register when that register is empty or being taken.
//   Throughput is one command per cycle while the receiver takes results;
//   the insert and tag-match chains across the cells set the cycle time.
//   When the receiver stalls, one result waits in the output register and
//   one more in the pending register; the input then holds tready low.
//   Reset empties the queue and drops any result not yet transferred.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // command[1:0], tag, priority_req
  input  logic [spq_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // status[1:0], out_tag, out_priority, head_valid, head_tag, head_priority, count
  output logic [spq_pkg::OUT_W-1:0] out_tdata
);

  localparam int TB = spq_pkg::TAG_BITS;
  localparam int PB = spq_pkg::PRIO_BITS;
  localparam int CB = spq_pkg::CNT_BITS;
  localparam int N  = spq_pkg::DEPTH;

  spq_pkg::entry_t ents  [N];
  spq_pkg::link_t  links [N+1];
  spq_pkg::op_t    op;

  logic [1:0]    in_cmd;
  logic [TB-1:0] in_tag;
  logic [PB-1:0] in_prio;
  logic          accept;
  logic          move;

  logic [CB-1:0] count_r;
  logic [CB-1:0] count_nxt;
  logic [1:0]    status;
  logic [TB-1:0] res_tag;
  logic [PB-1:0] res_prio;
  logic          do_op;

  logic          p_valid_r;
  logic [1:0]    p_status_r;
  logic [TB-1:0] p_tag_r;
  logic [PB-1:0] p_prio_r;

  logic                             out_valid_r;
  logic [spq_pkg::OUT_BITS-1:0]     out_data_r;
  logic [TB-1:0]                    head_tag;
  logic [PB-1:0]                    head_prio;

  assign in_cmd  = in_tdata[1:0];
  assign in_tag  = in_tdata[2 +: TB];
  assign in_prio = in_tdata[2+TB +: PB];

  assign move      = p_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !p_valid_r || move;
  assign accept    = in_tvalid && in_tready;

  assign links[0] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      spq_pkg::entry_t prev_ent;
      spq_pkg::entry_t next_ent;
      if (gi == 0) begin : g_first
        assign prev_ent = '0;
      end else begin : g_mid
        assign prev_ent = ents[gi-1];
      end
      if (gi == N - 1) begin : g_last
        assign next_ent = '0;
      end else begin : g_inner
        assign next_ent = ents[gi+1];
      end
      spq_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .prev_ent  (prev_ent),
        .next_ent  (next_ent),
        .chain_in  (links[gi]),
        .chain_out (links[gi+1]),
        .ent       (ents[gi])
      );
    end
  endgenerate

  always_comb begin
    status    = spq_pkg::ST_OK;
    res_tag   = '0;
    res_prio  = '0;
    do_op     = 1'b0;
    count_nxt = count_r;
    case (in_cmd)
      spq_pkg::CMD_PUSH: begin
        if (count_r == CB'(N)) begin
          status = spq_pkg::ST_FULL;
        end else begin
          do_op     = 1'b1;
          count_nxt = count_r + CB'(1);
        end
      end
      spq_pkg::CMD_POP: begin
        if (count_r == '0) begin
          status = spq_pkg::ST_EMPTY;
        end else begin
          do_op     = 1'b1;
          res_tag   = ents[0].tag;
          res_prio  = ents[0].prio;
          count_nxt = count_r - CB'(1);
        end
      end
      spq_pkg::CMD_REMOVE: begin
        if (!links[N].hit) begin
          status = spq_pkg::ST_NOTFOUND;
        end else begin
          do_op     = 1'b1;
          res_tag   = links[N].tag;
          res_prio  = links[N].prio;
          count_nxt = count_r - CB'(1);
        end
      end
      default: begin
        status = spq_pkg::ST_OK;
      end
    endcase
  end

  assign op.en   = accept && do_op;
  assign op.cmd  = in_cmd;
  assign op.tag  = in_tag;
  assign op.prio = in_prio;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        p_valid_r <= 1'b1;
      end else if (move) begin
        p_valid_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_status_r <= status;
      p_tag_r    <= res_tag;
      p_prio_r   <= res_prio;
    end
  end

  assign head_tag  = ents[0].valid ? ents[0].tag  : '0;
  assign head_prio = ents[0].valid ? ents[0].prio : '0;

  always_ff @(posedge clk) begin
    if (move) begin
      out_data_r <= {count_r, head_prio, head_tag, ents[0].valid,
                     p_prio_r, p_tag_r, p_status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = spq_pkg::OUT_W'(out_data_r);

endmodule

// ===== design/spq_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue port checker
// Watches the top-level ports for result consistency and output stalls.
// ----------------------------------------------------------------------------
module spq_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [spq_pkg::OUT_W-1:0] out_tdata
);

  localparam int TB  = spq_pkg::TAG_BITS;
  localparam int PB  = spq_pkg::PRIO_BITS;
  localparam int CB  = spq_pkg::CNT_BITS;
  localparam int HVP = 2 + TB + PB;
  localparam int CNP = HVP + 1 + TB + PB;

  logic [1:0]    o_status;
  logic          o_hvalid;
  logic [CB-1:0] o_count;

  assign o_status = out_tdata[1:0];
  assign o_hvalid = out_tdata[HVP];
  assign o_count  = out_tdata[CNP +: CB];

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> o_count <= CB'(spq_pkg::DEPTH) && o_hvalid == (o_count != '0))
    else $error("count or head flag inconsistent");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_status == spq_pkg::ST_EMPTY |-> o_count == '0)
    else $error("empty status with entries stored");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_status == spq_pkg::ST_FULL |-> o_count == CB'(spq_pkg::DEPTH))
    else $error("full status with room left");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result presented after reset");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
